### src/srsu_pkg.sv
// ----------------------------------------------------------------------------
// srsu_pkg
// Shared types and constants of the shift register sound resampler.
// ----------------------------------------------------------------------------
package srsu_pkg;

  localparam int unsigned BPS_W      = 22;
  localparam int unsigned SAMPLE_W   = 12;
  localparam int unsigned WAVE_W     = 8;
  localparam int unsigned K_W        = $clog2(SAMPLE_W);
  localparam int unsigned ADDR_W     = 4;
  localparam int unsigned DATA_W     = 32;

  localparam logic [BPS_W-1:0]    BPS_RESET  = 22'd45875;
  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 12'd4095;

  typedef enum logic [1:0] {
    REG_SOUND_ON    = 2'd0,
    REG_MANUAL_HIGH = 2'd1,
    REG_WAVEFORM    = 2'd2,
    REG_BPS         = 2'd3
  } reg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_WALK = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_OUT  = 4'b1000
  } state_e;

  typedef struct packed {
    logic              sound_on;
    logic              manual_high;
    logic [WAVE_W-1:0] waveform;
    logic [BPS_W-1:0]  bps;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic walk;
    logic div_init;
    logic div_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic direct;
    logic cnt_zero;
    logic div_last;
  } sts_t;

  // Pattern bit at a position, bit 7 of the pattern is position 0.
  function automatic logic pat_bit(input logic [WAVE_W-1:0] wave, input logic [2:0] pos);
    logic [2:0] idx;
    idx = 3'd7 - pos;
    return wave[idx];
  endfunction

endpackage

### src/srsu_regs.sv
// ----------------------------------------------------------------------------
// srsu_regs
// APB register file: sound enable, manual level, waveform, bits per sample.
// ----------------------------------------------------------------------------
module srsu_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [srsu_pkg::ADDR_W-1:0]   paddr,
  input  logic [srsu_pkg::DATA_W-1:0]   pwdata,
  output logic [srsu_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output srsu_pkg::cfg_t                cfg_o
);
  import srsu_pkg::*;

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[3:2]);
  assign wr_en  = psel & penable & pwrite & pready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_SOUND_ON:    cfg_d.sound_on    = pwdata[0];
        REG_MANUAL_HIGH: cfg_d.manual_high = pwdata[0];
        REG_WAVEFORM:    cfg_d.waveform    = pwdata[WAVE_W-1:0];
        REG_BPS:         cfg_d.bps         = pwdata[BPS_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_SOUND_ON:    prdata = DATA_W'(cfg_q.sound_on);
      REG_MANUAL_HIGH: prdata = DATA_W'(cfg_q.manual_high);
      REG_WAVEFORM:    prdata = DATA_W'(cfg_q.waveform);
      REG_BPS:         prdata = DATA_W'(cfg_q.bps);
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sound_on    <= 1'b0;
      cfg_q.manual_high <= 1'b0;
      cfg_q.waveform    <= '0;
      cfg_q.bps         <= BPS_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### src/srsu_ctrl.sv
// ----------------------------------------------------------------------------
// srsu_ctrl
// Sequencer: load, bit walk, restoring division, output register handoff.
// ----------------------------------------------------------------------------
module srsu_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  input  srsu_pkg::sts_t sts_i,
  output srsu_pkg::cmd_t cmd_o
);
  import srsu_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = sts_i.direct ? ST_OUT : ST_WALK;
        end
      end
      ST_WALK: begin
        if (sts_i.cnt_zero) begin
          cmd_o.div_init = 1'b1;
          state_d        = ST_DIV;
        end else begin
          cmd_o.walk = 1'b1;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q & out_stall_i;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

### src/srsu_dp.sv
// ----------------------------------------------------------------------------
// srsu_dp
// Datapath: bit phase, window setup, whole-bit walk, level*4095/width divide.
// ----------------------------------------------------------------------------
module srsu_dp #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  srsu_pkg::cfg_t                  cfg_i,
  input  logic                            waveform_reloaded_i,
  input  srsu_pkg::cmd_t                  cmd_i,
  output srsu_pkg::sts_t                  sts_o,
  output logic [srsu_pkg::SAMPLE_W-1:0]   sample_o
);
  import srsu_pkg::*;

  localparam int unsigned PH_W  = 3 + FRAC_BITS;
  localparam int unsigned E_W   = ((PH_W > BPS_W) ? PH_W : BPS_W) + 1;
  localparam int unsigned EF_W  = E_W - FRAC_BITS;
  localparam int unsigned N_W   = BPS_W + SAMPLE_W;
  localparam logic [E_W-1:0] ONE_E = E_W'(1) << FRAC_BITS;

  logic [PH_W-1:0]     phase_q, phase_eff;
  logic [E_W-1:0]      win_end, start_part, end_part, lvl_sum;
  logic [2:0]          sf;
  logic [EF_W-1:0]     ef, cnt_init;
  logic                same, bit_sf, bit_ef;
  logic [BPS_W-1:0]    lvl_init;
  logic [SAMPLE_W-1:0] direct_val;

  logic [WAVE_W-1:0]   wave_q;
  logic [BPS_W-1:0]    w_q, lvl_q;
  logic [EF_W-1:0]     cnt_q;
  logic [2:0]          pos_q;
  logic [N_W-1:0]      num_q, den_q;
  logic [K_W-1:0]      k_q;
  logic [SAMPLE_W-1:0] q_q, out_q;
  logic                ge;

  assign phase_eff = waveform_reloaded_i ? {3'b000, phase_q[FRAC_BITS-1:0]} : phase_q;
  assign win_end   = E_W'(phase_eff) + E_W'(cfg_i.bps);
  assign sf        = phase_eff[PH_W-1:FRAC_BITS];
  assign ef        = win_end[E_W-1:FRAC_BITS];
  assign same      = (EF_W'(sf) == ef);
  assign bit_sf    = pat_bit(cfg_i.waveform, sf);
  assign bit_ef    = pat_bit(cfg_i.waveform, ef[2:0]);

  assign start_part = ONE_E - E_W'(phase_eff[FRAC_BITS-1:0]);
  assign end_part   = E_W'(win_end[FRAC_BITS-1:0]);
  assign lvl_sum    = (bit_sf ? start_part : '0) + (bit_ef ? end_part : '0);
  assign lvl_init   = same ? (bit_sf ? cfg_i.bps : '0) : BPS_W'(lvl_sum);
  assign cnt_init   = same ? '0 : EF_W'(ef - EF_W'(sf) - EF_W'(1));

  assign direct_val = (!cfg_i.sound_on && cfg_i.manual_high) ? SAMPLE_MAX : '0;
  assign ge         = (num_q >= den_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
    end else if (cmd_i.load) begin
      phase_q <= win_end[PH_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      wave_q <= cfg_i.waveform;
      w_q    <= cfg_i.bps;
      lvl_q  <= lvl_init;
      cnt_q  <= cnt_init;
      pos_q  <= sf + 3'd1;
      q_q    <= direct_val;
    end
    if (cmd_i.walk) begin
      if (pat_bit(wave_q, pos_q)) begin
        lvl_q <= lvl_q + BPS_W'(ONE_E);
      end
      cnt_q <= cnt_q - EF_W'(1);
      pos_q <= pos_q + 3'd1;
    end
    if (cmd_i.div_init) begin
      num_q <= {lvl_q, SAMPLE_W'(0)} - N_W'(lvl_q);
      den_q <= N_W'(w_q) << (SAMPLE_W - 1);
      k_q   <= K_W'(SAMPLE_W - 1);
      q_q   <= '0;
    end
    if (cmd_i.div_step) begin
      if (ge) begin
        num_q <= num_q - den_q;
      end
      den_q <= den_q >> 1;
      k_q   <= k_q - K_W'(1);
      q_q   <= {q_q[SAMPLE_W-2:0], ge};
    end
    if (cmd_i.out_load) begin
      out_q <= q_q;
    end
  end

  assign sts_o.direct   = !cfg_i.sound_on || (cfg_i.bps == '0);
  assign sts_o.cnt_zero = (cnt_q == '0);
  assign sts_o.div_last = (k_q == '0);
  assign sample_o       = out_q;

endmodule

### src/shift_register_sound_resampler_unit.sv
// ----------------------------------------------------------------------------
// shift_register_sound_resampler_unit
// Box-filters a repeating 8-bit pattern over a window of bits_per_sample
// and scales the set time to a 12-bit sample, one sample per input beat.
//
//   channel   direction  handshake                payload
//   input     in         in_valid_i/in_stall_o    waveform_reloaded_i
//   result    out        out_valid_o/out_stall_i  sample_o
//   config    in/out     APB psel/penable         paddr, pwdata, prdata
//
// Steps per beat: load, walk of W bits, divide setup, divide, output handoff,
// where W is the number of whole pattern bits strictly inside the window (0 at
// the default width); sound off or zero width skips walk and divide.
// The walk and the one-bit-per-cycle restoring divider set the beat time.
// Reset clears the phase, the registers and the sequencer; no clearing pass.
// A full output register holds the finished beat while the next one is taken.
// ----------------------------------------------------------------------------
module shift_register_sound_resampler_unit #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [srsu_pkg::ADDR_W-1:0]   paddr,
  input  logic [srsu_pkg::DATA_W-1:0]   pwdata,
  output logic [srsu_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          waveform_reloaded_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [srsu_pkg::SAMPLE_W-1:0] sample_o
);
  import srsu_pkg::*;

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  srsu_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  srsu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  srsu_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_i               (cfg),
    .waveform_reloaded_i (waveform_reloaded_i),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .sample_o            (sample_o)
  );

  // one beat in flight at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input taken while previous beat still in flight");

  // a result only appears from a beat that was being worked on
  a_result_has_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result produced with no beat in flight");

  // a sound-off beat finishes without the walk and divide
  a_direct_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && !cfg.sound_on && !out_valid_o) |=> ##1 out_valid_o)
    else $error("sound-off beat did not complete in two cycles");

endmodule
